// ===== rtl/first_fit_block_allocator_top_defines.svh =====
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define FFBA_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ffba assertion failed");
`define FFBA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ffba assertion failed");
`else
`define FFBA_ASSERT(label, clk, rst, prop)
`define FFBA_ASSERT_NR(label, clk, prop)
`endif

`endif

// ===== rtl/ffba_pkg.sv =====
// Shared constants and types of the first-fit block allocator.
package ffba_pkg;

  localparam int ARENA_BYTES_DEF   = 1024;
  localparam int GRANULE_BYTES_DEF = 16;

  localparam int REQ_W    = 10;
  localparam int OFF_W    = 10;
  localparam int STATUS_W = 2;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADADDR = 2'd2
  } status_t;

endpackage

// ===== rtl/ffba_ifs.sv =====
// Request and response channel interfaces of the first-fit block allocator.
interface ffba_req_if;
  import ffba_pkg::*;

  logic             valid;
  logic             ready;
  kind_t            kind;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] release_offset;

  modport source (output valid, output kind, output request_bytes,
                  output release_offset, input ready);
  modport sink   (input valid, input kind, input request_bytes,
                  input release_offset, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] grant_offset;
  status_t          status;

  modport source (output valid, output grant_offset, output status, input ready);
  modport sink   (input valid, input grant_offset, input status, output ready);
endinterface

// ===== rtl/first_fit_block_allocator_top.sv =====
// First-fit block allocator: header table in one synchronous RAM, walked per item.
//
//   channel  dir  payload                                  transfer
//   req      in   kind, request_bytes, release_offset      valid && ready
//   rsp      out  grant_offset, status                     valid && ready
//
// Allocate/free: S_IDLE, S_RD, S_EVAL once per header walked (H = 1..ARENA/GRANULE),
// S_SPLIT on a split, then S_DONE; one header read per cycle from the table RAM.
// Misaligned or zero free offset: S_IDLE straight to S_DONE, no table access.
// Reset: no clearing pass; entry 0 reads as the full free block until first written.
// rsp is registered: a new item is taken while a result waits, and the next
// result waits until the register is free.
`include "first_fit_block_allocator_top_defines.svh"

module first_fit_block_allocator_top #(
  parameter int ARENA_BYTES   = ffba_pkg::ARENA_BYTES_DEF,
  parameter int GRANULE_BYTES = ffba_pkg::GRANULE_BYTES_DEF
) (
  input logic         clk,
  input logic         rst,
  ffba_req_if.sink    req,
  ffba_rsp_if.source  rsp
);
  import ffba_pkg::*;

  localparam int GSH   = $clog2(GRANULE_BYTES);
  localparam int NGRAN = ARENA_BYTES / GRANULE_BYTES;
  localparam int IDX_W = $clog2(NGRAN);
  localparam int ENT_W = IDX_W + 1;
  localparam int AW    = (IDX_W + 2 > REQ_W + 1) ? IDX_W + 2 : REQ_W + 1;
  localparam int GO_W  = AW + GSH;

  localparam logic [ENT_W-1:0] RESET_ENT = {1'b0, IDX_W'(NGRAN - 1)};
  localparam logic [AW-1:0]    NGRAN_A   = AW'(NGRAN);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RD    = 5'b00010,
    S_EVAL  = 5'b00100,
    S_SPLIT = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t           state, state_next;
  logic [AW-1:0]    g, g_next;
  kind_t            kind, kind_next;
  logic [AW-1:0]    need, need_next;
  logic [AW-1:0]    target, target_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  status_t          res_st, res_st_next;
  logic             e0_init, e0_init_next;
  logic             out_valid, out_valid_next;
  logic [OFF_W-1:0] out_off, out_off_next;
  status_t          out_st, out_st_next;

  logic [ENT_W-1:0] mem [NGRAN];
  logic [ENT_W-1:0] mem_q;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_raddr, mem_waddr;
  logic [ENT_W-1:0] mem_wdata;

  logic [REQ_W:0]   nsum;
  logic             bad_off;
  logic [ENT_W-1:0] ent;
  logic             used;
  logic [AW-1:0]    sz, walk_next, nh, rest;
  logic [GO_W-1:0]  goff;
  logic             fit, split;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_q <= mem[mem_raddr];
  end

  assign nsum    = (REQ_W + 1)'(req.request_bytes) + (REQ_W + 1)'(GRANULE_BYTES - 1);
  assign bad_off = ((req.release_offset & OFF_W'(GRANULE_BYTES - 1)) != '0) ||
                   (req.release_offset == '0);

  assign ent       = (e0_init && g == '0) ? RESET_ENT : mem_q;
  assign used      = ent[IDX_W];
  assign sz        = AW'(ent[IDX_W-1:0]);
  assign walk_next = g + AW'(1) + sz;
  assign nh        = g + AW'(1) + need;
  assign rest      = sz - need - AW'(1);
  assign goff      = GO_W'(g + AW'(1)) << GSH;
  assign fit       = !used && (sz >= need);
  assign split     = (sz >= need + AW'(2)) && (nh < NGRAN_A);

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.grant_offset = out_off;
  assign rsp.status    = out_st;

  always_comb begin
    state_next     = state;
    g_next         = g;
    kind_next      = kind;
    need_next      = need;
    target_next    = target;
    res_off_next   = res_off;
    res_st_next    = res_st;
    e0_init_next   = e0_init;
    out_valid_next = out_valid && !rsp.ready;
    out_off_next   = out_off;
    out_st_next    = out_st;
    mem_re         = 1'b0;
    mem_raddr      = g[IDX_W-1:0];
    mem_we         = 1'b0;
    mem_waddr      = g[IDX_W-1:0];
    mem_wdata      = {1'b0, ent[IDX_W-1:0]};

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          kind_next   = req.kind;
          need_next   = AW'(nsum >> GSH);
          target_next = AW'(req.release_offset >> GSH) - AW'(1);
          g_next      = '0;
          if (req.kind == KIND_FREE && bad_off) begin
            res_off_next = '0;
            res_st_next  = ST_BADADDR;
            state_next   = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        mem_re     = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        if (kind == KIND_ALLOC) begin
          if (fit) begin
            res_off_next = OFF_W'(goff);
            res_st_next  = ST_OK;
            mem_we       = 1'b1;
            if (split) begin
              mem_waddr  = nh[IDX_W-1:0];
              mem_wdata  = {1'b0, rest[IDX_W-1:0]};
              state_next = S_SPLIT;
            end else begin
              mem_wdata  = {1'b1, ent[IDX_W-1:0]};
              state_next = S_DONE;
            end
          end else if (walk_next < NGRAN_A) begin
            g_next    = walk_next;
            mem_re    = 1'b1;
            mem_raddr = walk_next[IDX_W-1:0];
          end else begin
            res_off_next = '0;
            res_st_next  = ST_NOFIT;
            state_next   = S_DONE;
          end
        end else begin
          if (g == target) begin
            mem_we       = 1'b1;
            mem_wdata    = {1'b0, ent[IDX_W-1:0]};
            res_off_next = '0;
            res_st_next  = ST_OK;
            state_next   = S_DONE;
          end else if (walk_next < NGRAN_A && walk_next <= target) begin
            g_next    = walk_next;
            mem_re    = 1'b1;
            mem_raddr = walk_next[IDX_W-1:0];
          end else begin
            res_off_next = '0;
            res_st_next  = ST_BADADDR;
            state_next   = S_DONE;
          end
        end
      end
      S_SPLIT: begin
        mem_we     = 1'b1;
        mem_wdata  = {1'b1, need[IDX_W-1:0]};
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_off_next   = res_off;
          out_st_next    = res_st;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (mem_we && mem_waddr == '0) e0_init_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      e0_init   <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      e0_init   <= e0_init_next;
      out_valid <= out_valid_next;
    end
    g       <= g_next;
    kind    <= kind_next;
    need    <= need_next;
    target  <= target_next;
    res_off <= res_off_next;
    res_st  <= res_st_next;
    out_off <= out_off_next;
    out_st  <= out_st_next;
  end

  `FFBA_ASSERT(a_accept_busy, clk, rst, req.valid && req.ready |=> state != S_IDLE)
  `FFBA_ASSERT(a_write_phase, clk, rst, mem_we |-> (state == S_EVAL || state == S_SPLIT))
  `FFBA_ASSERT(a_fail_zero_off, clk, rst, rsp.valid && rsp.status != ST_OK |-> rsp.grant_offset == '0)
  `FFBA_ASSERT_NR(a_e0_cleared, clk, !rst && $fell(e0_init) |-> $past(mem_we && mem_waddr == '0))
endmodule

// ===== tb/ffba_grant_checker.sv =====
// Checker for the first-fit block allocator: predicts every result and compares it.
`timescale 1ns / 1ps

module ffba_grant_checker (
  input  logic clk,
  input  logic rst,
  ffba_req_if  req,
  ffba_rsp_if  rsp,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);
  import ffba_pkg::*;

  localparam int GRAN_B = GRANULE_BYTES_DEF;
  localparam int NGRAN  = ARENA_BYTES_DEF / GRANULE_BYTES_DEF;

  typedef struct packed {
    logic       used;
    logic [7:0] size;
  } block_hdr_t;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    status_t          status;
  } grant_t;

  block_hdr_t hdr_table [NGRAN];
  grant_t     grant_q [$];

  // Applies one item to the header table and returns the result it should produce.
  function automatic grant_t predict_grant(kind_t k, int bytes, int offset);
    grant_t r;
    int     need;
    int     target;
    int     g;
    int     sz;
    r.offset = '0;
    g = 0;
    if (k == KIND_ALLOC) begin
      r.status = ST_NOFIT;
      need = (bytes + GRAN_B - 1) / GRAN_B;
      while (g < NGRAN) begin
        sz = int'(hdr_table[g].size);
        if (!hdr_table[g].used && sz >= need) begin
          // split when a header plus one granule is left over
          if (sz >= need + 2) begin
            hdr_table[g + 1 + need] = '{used: 1'b0, size: 8'(sz - need - 1)};
            sz = need;
          end
          hdr_table[g] = '{used: 1'b1, size: 8'(sz)};
          r.offset = OFF_W'((g + 1) * GRAN_B);
          r.status = ST_OK;
          return r;
        end
        g += 1 + sz;
      end
    end else begin
      r.status = ST_BADADDR;
      if (offset % GRAN_B != 0 || offset == 0) return r;
      target = offset / GRAN_B - 1;
      while (g < NGRAN && g <= target) begin
        if (g == target) begin
          hdr_table[g].used = 1'b0;
          r.status = ST_OK;
          return r;
        end
        g += 1 + int'(hdr_table[g].size);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      for (int i = 0; i < NGRAN; i++) hdr_table[i] = '0;
      hdr_table[0].size = 8'(NGRAN - 1);
      grant_q.delete();
      fail_count = 0;
      checked_count = 0;
    end else begin
      if (req.valid && req.ready)
        grant_q.push_back(predict_grant(req.kind, int'(req.request_bytes),
                                        int'(req.release_offset)));
      if (rsp.valid && rsp.ready) begin
        if (grant_q.size() == 0) begin
          report_mismatch("unexpected transfer, grant_offset", int'(rsp.grant_offset), -1);
        end else begin
          want = grant_q.pop_front();
          checked_count++;
          if (rsp.grant_offset !== want.offset)
            report_mismatch("grant_offset", int'(rsp.grant_offset), int'(want.offset));
          if (rsp.status !== want.status)
            report_mismatch("status", int'(rsp.status), int'(want.status));
        end
      end
    end
    pending = grant_q.size();
  end

endmodule

// ===== tb/tb_first_fit_block_allocator_top.sv =====
// Testbench top for the first-fit block allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_first_fit_block_allocator_top;
  import ffba_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 100;
  localparam int ITEMS_PER_PHASE = 250;

  logic clk;
  logic rst;

  ffba_req_if req_ch ();
  ffba_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int checked_count;
  int stall_cycles;
  int send_idle_pct;
  int recv_idle_pct;
  int n_alloc;
  int n_free;
  bit hold_go;
  bit holdoff;
  int live_grants [$];

  first_fit_block_allocator_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ffba_grant_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= !holdoff && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    holdoff = 1'b0;
    wait (hold_go);
    @(posedge clk);
    holdoff = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holdoff = 1'b0;
  end

  // payload offsets handed out so far, used to build well-formed frees
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ST_OK &&
        rsp_ch.grant_offset != '0)
      live_grants.push_back(int'(rsp_ch.grant_offset));
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(kind_t k, int rb, int ro);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.kind           <= k;
    req_ch.request_bytes  <= rb[REQ_W-1:0];
    req_ch.release_offset <= ro[OFF_W-1:0];
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    if (k == KIND_ALLOC) n_alloc++;
    else n_free++;
  endtask

  task automatic send_random_item();
    int pick;
    int idx;
    int rb;
    int ro;
    pick = $urandom_range(99);
    if (pick < 50) begin
      pick = $urandom_range(99);
      if (pick < 80) rb = $urandom_range(64);
      else if (pick < 95) rb = $urandom_range(300, 65);
      else rb = $urandom_range(1008, 301);
      send_item(KIND_ALLOC, rb, $urandom_range(1023));
    end else begin
      if (pick < 85 && live_grants.size() > 0) begin
        idx = $urandom_range(live_grants.size() - 1);
        ro = live_grants[idx];
        live_grants.delete(idx);
      end else if ($urandom_range(1)) begin
        ro = $urandom_range(63) * 16;
      end else begin
        ro = $urandom_range(1023);
      end
      send_item(KIND_FREE, $urandom_range(1008), ro);
    end
  endtask

  task automatic drain_pause();
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic run_phase(int s_pct, int r_pct, bit with_hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (with_hold) hold_go = 1'b1;
    repeat (ITEMS_PER_PHASE) send_random_item();
    drain_pause();
  endtask

  initial begin
    rst                   = 1'b1;
    req_ch.valid          = 1'b0;
    req_ch.kind           = KIND_ALLOC;
    req_ch.request_bytes  = '0;
    req_ch.release_offset = '0;
    hold_go               = 1'b0;
    send_idle_pct         = 18;
    recv_idle_pct         = 70;
    n_alloc               = 0;
    n_free                = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // whole arena, zero-byte split, exact fits, misaligned and stale frees
    send_item(KIND_ALLOC, 1008, $urandom_range(1023));
    send_item(KIND_ALLOC, 0, $urandom_range(1023));
    send_item(KIND_FREE, $urandom_range(1008), 16);
    send_item(KIND_FREE, $urandom_range(1008), 16);
    send_item(KIND_ALLOC, 0, $urandom_range(1023));
    send_item(KIND_ALLOC, 1008, $urandom_range(1023));
    send_item(KIND_ALLOC, 1, $urandom_range(1023));
    send_item(KIND_ALLOC, 16, $urandom_range(1023));
    send_item(KIND_ALLOC, 17, $urandom_range(1023));
    send_item(KIND_FREE, $urandom_range(1008), 8);
    send_item(KIND_FREE, $urandom_range(1008), 0);
    send_item(KIND_FREE, $urandom_range(1008), 1023);
    send_item(KIND_FREE, $urandom_range(1008), 48);
    send_item(KIND_FREE, $urandom_range(1008), 32);
    send_item(KIND_ALLOC, 15, $urandom_range(1023));
    send_item(KIND_FREE, $urandom_range(1008), 16);
    send_item(KIND_ALLOC, 0, $urandom_range(1023));
    send_item(KIND_ALLOC, 880, $urandom_range(1023));
    send_item(KIND_ALLOC, 1, $urandom_range(1023));
    send_item(KIND_FREE, $urandom_range(1008), 144);
    send_item(KIND_ALLOC, 864, $urandom_range(1023));
    send_item(KIND_FREE, $urandom_range(1008), 1008);
    send_item(KIND_FREE, $urandom_range(1008), 1000);
    send_item(KIND_FREE, $urandom_range(1008), 144);
    send_item(KIND_ALLOC, 0, $urandom_range(1023));
    drain_pause();

    run_phase(18, 70, 1'b0);
    run_phase(70, 18, 1'b0);
    run_phase(0, 0, 1'b1);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d allocate and %0d free transfers, %0d results checked",
             n_alloc, n_free, checked_count);
    $display("Idle mixes: slow receiver, slow sender, none; one long response hold-off");
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
